FILE: rtl/core/polyline_simplifier_assert.svh
// Assertion macros used by the polyline simplifier checker
`ifndef POLYLINE_SIMPLIFIER_ASSERT_SVH
`define POLYLINE_SIMPLIFIER_ASSERT_SVH

// implication in the same cycle, off while in reset
`define PS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication into the next cycle, off while in reset
`define PS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define PS_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/polysim_pkg.sv
// Package: types and constants of the polyline simplifier
package polysim_pkg;

   localparam int MaxPointsDef = 64;
   localparam int PointW       = 16;
   localparam int TolW         = 15;
   localparam logic [TolW-1:0] TolReset = 15'd19;
   localparam int Eps2W        = 2 * TolW;
   localparam int DiffW        = PointW + 1;
   localparam int L2W          = 2 * DiffW;
   localparam int MulW         = L2W + 1;
   localparam int ProdW        = 66;
   localparam int DistW        = MulW;
   localparam int SqLimitBit   = 32;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EPS,
      ST_EPS_WAIT,
      ST_POP,
      ST_SEG,
      ST_RD_E,
      ST_AXAY,
      ST_L2A,
      ST_L2B,
      ST_L2C,
      ST_PT_RD,
      ST_PT_GET,
      ST_D1,
      ST_D2,
      ST_D3,
      ST_DEC,
      ST_K1,
      ST_K2,
      ST_K3,
      ST_PUSH1,
      ST_PUSH2,
      ST_E_SCAN,
      ST_E_GET
   } state_type;

endpackage

FILE: rtl/core/polysim_ram.sv
// Generic simple dual-port RAM with registered read
module polysim_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/polysim_mul.sv
// Shared signed multiplier with registered product
module polysim_mul (
   input  logic                               clock,
   input  logic signed [polysim_pkg::MulW-1:0] op_a,
   input  logic signed [polysim_pkg::MulW-1:0] op_b,
   output logic signed [polysim_pkg::ProdW-1:0] prod
);
   import polysim_pkg::*;

   logic signed [2*MulW-1:0] full;
   logic signed [ProdW-1:0]  prod_ff;

   // products stay below 2^64 in magnitude, so the top bits are sign copies
   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full[ProdW-1:0];
   end

   assign prod = prod_ff;
endmodule

FILE: rtl/core/polyline_simplifier.sv
// Top level: point store, segment stack and the simplification sequencer
// Polyline simplifier (Ramer-Douglas-Peucker). Points enter one word per
// cycle on req_* and are written into a point store of MAX_POINTS entries;
// loads past that are dropped. The word flagged final_point closes the
// polyline and the block drops req_ready until the last result word has
// been loaded into the output register. With three or more points a run
// follows: the tolerance is squared, then each segment popped from the
// stack is set up, the distance of each interior point is measured, and a
// keep test decides on the pushes; every product goes through one shared
// 35x35 multiplier. The result phase scans the kept map one index per cycle,
// pausing for each word sent until the output register is free, and
// sends each kept point as one rsp_ word:
// first point, kept interior points in index order, last point with
// end_of_run set; a single point is sent twice. The tolerance register
// (unsigned Q15.0) is written through csr_wr_en / csr_wr_data; the user
// must write it only while idle, and the block itself does not enforce it.
module polyline_simplifier #(
   parameter int MAX_POINTS = polysim_pkg::MaxPointsDef
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [polysim_pkg::TolW-1:0]       csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [polysim_pkg::PointW-1:0] req_x_in,
   input  logic signed [polysim_pkg::PointW-1:0] req_y_in,
   input  logic                               req_final_point,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [polysim_pkg::PointW-1:0] rsp_x_out,
   output logic signed [polysim_pkg::PointW-1:0] rsp_y_out,
   output logic                               rsp_end_of_run
);
   import polysim_pkg::*;

   localparam int IdxW   = $clog2(MAX_POINTS);
   localparam int CntW   = $clog2(MAX_POINTS + 1);
   localparam int SegW   = 2 * IdxW;
   localparam int StackDepth = MAX_POINTS;

   state_type state_ff, state_in;

   logic [TolW-1:0]   tol_ff;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [IdxW-1:0]   last_ff, last_in;
   logic [MAX_POINTS-1:0] kept_ff, kept_in;
   logic [CntW-1:0]   sp_ff, sp_in;
   logic [IdxW-1:0]   s_ff, s_in, e_ff, e_in, i_ff, i_in, best_ff, best_in, j_ff, j_in;
   logic              twice_ff, twice_in;
   logic signed [PointW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [DiffW-1:0]  ax_ff, ax_in, ay_ff, ay_in, px_ff, px_in, py_ff, py_in;
   logic [L2W-1:0]    l2_ff, l2_in;
   logic [Eps2W-1:0]  eps2_ff, eps2_in;
   logic [DistW-1:0]  best_d_ff, best_d_in;
   logic signed [ProdW-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in, eor_ff, eor_in;
   logic signed [PointW-1:0] xo_ff, xo_in, yo_ff, yo_in;

   // RAM and multiplier hookup
   logic              pt_we;
   logic [IdxW-1:0]   pt_waddr, pt_raddr;
   logic [2*PointW-1:0] pt_wdata, pt_rdata;
   logic              st_we;
   logic [IdxW-1:0]   st_waddr, st_raddr;
   logic [SegW-1:0]   st_wdata, st_rdata;
   logic signed [MulW-1:0]  mul_a, mul_b;
   logic signed [ProdW-1:0] prod;

   // helpers
   logic              accept, store_ok, l2_zero, out_free, emit_here, last_emit;
   logic [CntW-1:0]   cnt_n;
   logic signed [PointW-1:0] rd_x, rd_y;
   logic signed [ProdW-1:0]  dist_sum, dist_diff;
   logic [DistW-1:0]  pt_dist;
   logic              step_done, keep_big, keep_now, push_hi, push_lo;

   polysim_ram #(.Width(2 * PointW), .Depth(MAX_POINTS)) u_points (
      .clock(clock), .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
      .rd_addr(pt_raddr), .rd_data(pt_rdata)
   );

   polysim_ram #(.Width(SegW), .Depth(StackDepth)) u_stack (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   polysim_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(prod));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign store_ok  = (cnt_ff < CntW'(MAX_POINTS));
   assign cnt_n     = store_ok ? cnt_ff + 1'b1 : cnt_ff;
   assign rd_x      = pt_rdata[2*PointW-1:PointW];
   assign rd_y      = pt_rdata[PointW-1:0];
   assign l2_zero   = (ax_ff == '0) && (ay_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // distance of the current interior point from the two products
   assign dist_sum  = acc_ff + prod;
   assign dist_diff = acc_ff - prod;
   assign pt_dist   = l2_zero ? dist_sum[DistW-1:0]
                    : (dist_diff[ProdW-1] ? DistW'(-dist_diff) : dist_diff[DistW-1:0]);

   assign step_done = ({1'b0, i_ff} + 1'b1) == {1'b0, e_ff};
   assign keep_big  = (best_d_ff[DistW-1:SqLimitBit] != '0);
   assign keep_now  = best_d_ff >= DistW'(eps2_ff);
   assign push_hi   = ({1'b0, e_ff} >= {1'b0, best_ff} + 2'd2) && (sp_ff < CntW'(StackDepth));
   assign push_lo   = ({1'b0, best_ff} >= {1'b0, s_ff} + 2'd2) && (sp_ff < CntW'(StackDepth));

   // emission: end points always, interior points when kept
   assign emit_here = (j_ff == '0) || (j_ff == last_ff) || kept_ff[j_ff];
   assign last_emit = (j_ff == last_ff) && !((last_ff == '0) && !twice_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_final_point) begin
               state_in = (cnt_n >= CntW'(3)) ? ST_EPS : ST_E_SCAN;
            end
         end
         ST_EPS:      state_in = ST_EPS_WAIT;
         ST_EPS_WAIT: state_in = ST_POP;
         ST_POP:      state_in = (sp_ff == '0) ? ST_E_SCAN : ST_SEG;
         ST_SEG:      state_in = ST_RD_E;
         ST_RD_E:     state_in = ST_AXAY;
         ST_AXAY:     state_in = ST_L2A;
         ST_L2A:      state_in = ST_L2B;
         ST_L2B:      state_in = ST_L2C;
         ST_L2C:      state_in = ST_PT_RD;
         ST_PT_RD:    state_in = ST_PT_GET;
         ST_PT_GET:   state_in = ST_D1;
         ST_D1:       state_in = ST_D2;
         ST_D2:       state_in = ST_D3;
         ST_D3:       state_in = step_done ? ST_DEC : ST_PT_RD;
         ST_DEC: begin
            if (best_d_ff == '0) begin
               state_in = ST_POP;
            end else if (l2_zero) begin
               state_in = keep_now ? ST_PUSH1 : ST_POP;
            end else if (keep_big) begin
               state_in = ST_PUSH1;
            end else begin
               state_in = ST_K1;
            end
         end
         ST_K1:       state_in = ST_K2;
         ST_K2:       state_in = ST_K3;
         ST_K3:       state_in = (acc_ff >= prod) ? ST_PUSH1 : ST_POP;
         ST_PUSH1:    state_in = ST_PUSH2;
         ST_PUSH2:    state_in = ST_POP;
         ST_E_SCAN:   state_in = emit_here ? ST_E_GET : ST_E_SCAN;
         ST_E_GET: begin
            if (out_free && last_emit) begin
               state_in = ST_IDLE;
            end else if (out_free && !(last_ff == '0)) begin
               state_in = ST_E_SCAN;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath, memory and multiplier controls
   always_comb begin
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      kept_in   = kept_ff;
      sp_in     = sp_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      i_in      = i_ff;
      best_in   = best_ff;
      j_in      = j_ff;
      twice_in  = twice_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      l2_in     = l2_ff;
      eps2_in   = eps2_ff;
      best_d_in = best_d_ff;
      acc_in    = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      eor_in    = eor_ff;
      xo_in     = xo_ff;
      yo_in     = yo_ff;
      pt_we     = 1'b0;
      pt_waddr  = cnt_ff[IdxW-1:0];
      pt_wdata  = {req_x_in, req_y_in};
      pt_raddr  = i_ff;
      st_we     = 1'b0;
      st_waddr  = sp_ff[IdxW-1:0];
      st_wdata  = {best_ff, e_ff};
      st_raddr  = sp_ff[IdxW-1:0] - 1'b1;
      mul_a     = MulW'(px_ff);
      mul_b     = MulW'(ay_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pt_we  = store_ok;
               cnt_in = cnt_n;
               if (req_final_point) begin
                  last_in  = IdxW'(cnt_n - 1'b1);
                  j_in     = '0;
                  twice_in = 1'b0;
                  if (cnt_n >= CntW'(3)) begin
                     // the whole polyline is the first segment
                     st_we    = 1'b1;
                     st_waddr = '0;
                     st_wdata = {IdxW'(0), IdxW'(cnt_n - 1'b1)};
                     sp_in    = CntW'(1);
                  end
               end
            end
         end
         ST_EPS: begin
            mul_a = MulW'(tol_ff);
            mul_b = MulW'(tol_ff);
         end
         ST_EPS_WAIT: eps2_in = prod[Eps2W-1:0];
         ST_POP: begin
            if (sp_ff != '0) begin
               sp_in = sp_ff - 1'b1;
            end
            j_in = '0;
         end
         ST_SEG: begin
            s_in     = st_rdata[SegW-1:IdxW];
            e_in     = st_rdata[IdxW-1:0];
            pt_raddr = st_rdata[SegW-1:IdxW];
         end
         ST_RD_E: begin
            pt_raddr = e_ff;
            sx_in    = rd_x;
            sy_in    = rd_y;
         end
         ST_AXAY: begin
            ax_in = DiffW'(rd_x) - DiffW'(sx_ff);
            ay_in = DiffW'(rd_y) - DiffW'(sy_ff);
         end
         ST_L2A: begin
            mul_a = MulW'(ax_ff);
            mul_b = MulW'(ax_ff);
         end
         ST_L2B: begin
            mul_a  = MulW'(ay_ff);
            mul_b  = MulW'(ay_ff);
            acc_in = prod;
         end
         ST_L2C: begin
            l2_in     = dist_sum[L2W-1:0];
            i_in      = s_ff + 1'b1;
            best_in   = '0;
            best_d_in = '0;
         end
         ST_PT_RD: pt_raddr = i_ff;
         ST_PT_GET: begin
            px_in = DiffW'(rd_x) - DiffW'(sx_ff);
            py_in = DiffW'(rd_y) - DiffW'(sy_ff);
         end
         ST_D1: begin
            mul_a = MulW'(px_ff);
            mul_b = l2_zero ? MulW'(px_ff) : MulW'(ay_ff);
         end
         ST_D2: begin
            mul_a  = MulW'(py_ff);
            mul_b  = l2_zero ? MulW'(py_ff) : MulW'(ax_ff);
            acc_in = prod;
         end
         ST_D3: begin
            // strict compare keeps the first of equal distances
            if (pt_dist > best_d_ff) begin
               best_d_in = pt_dist;
               best_in   = i_ff;
            end
            i_in = i_ff + 1'b1;
         end
         ST_K1: begin
            mul_a = $signed(best_d_ff);
            mul_b = $signed(best_d_ff);
         end
         ST_K2: begin
            mul_a  = MulW'(eps2_ff);
            mul_b  = MulW'(l2_ff);
            acc_in = prod;
         end
         ST_PUSH1: begin
            kept_in[best_ff] = 1'b1;
            st_wdata = {best_ff, e_ff};
            if (push_hi) begin
               st_we = 1'b1;
               sp_in = sp_ff + 1'b1;
            end
         end
         ST_PUSH2: begin
            st_wdata = {s_ff, best_ff};
            if (push_lo) begin
               st_we = 1'b1;
               sp_in = sp_ff + 1'b1;
            end
         end
         ST_E_SCAN: begin
            pt_raddr = j_ff;
            if (!emit_here) begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_E_GET: begin
            pt_raddr = j_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               xo_in  = rd_x;
               yo_in  = rd_y;
               eor_in = last_emit;
               if (last_emit) begin
                  cnt_in  = '0;
                  kept_in = '0;
                  sp_in   = '0;
               end else if (last_ff == '0) begin
                  twice_in = 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= TolReset;
         cnt_ff       <= '0;
         kept_ff      <= '0;
         sp_ff        <= '0;
         twice_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         cnt_ff       <= cnt_in;
         kept_ff      <= kept_in;
         sp_ff        <= sp_in;
         twice_ff     <= twice_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      i_ff      <= i_in;
      best_ff   <= best_in;
      j_ff      <= j_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      l2_ff     <= l2_in;
      eps2_ff   <= eps2_in;
      best_d_ff <= best_d_in;
      acc_ff    <= acc_in;
      eor_ff    <= eor_in;
      xo_ff     <= xo_in;
      yo_ff     <= yo_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_out      = xo_ff;
   assign rsp_y_out      = yo_ff;
   assign rsp_end_of_run = eor_ff;
endmodule

FILE: rtl/core/polysim_checker.sv
// Port-level checker for the polyline simplifier, bound to the top level
`include "polyline_simplifier_assert.svh"

module polysim_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_wr_en,
   input logic [polysim_pkg::TolW-1:0]       csr_wr_data,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [polysim_pkg::PointW-1:0] req_x_in,
   input logic signed [polysim_pkg::PointW-1:0] req_y_in,
   input logic                               req_final_point,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [polysim_pkg::PointW-1:0] rsp_x_out,
   input logic signed [polysim_pkg::PointW-1:0] rsp_y_out,
   input logic                               rsp_end_of_run
);
   `PS_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_valid, "result word valid after reset")
   `PS_ASSERT_NEXT(a_busy_after_final, req_valid && req_ready && req_final_point, !req_ready, "ready after final word")
   `PS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_x_in) && $stable(req_y_in) && $stable(req_final_point), "stalled request word changed")
   `PS_ASSERT_NOW(a_csr_idle, csr_wr_en, req_ready && !$isunknown(csr_wr_data), "tolerance written while busy")
   `PS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_x_out) && $stable(rsp_y_out) && $stable(rsp_end_of_run), "stalled result word changed")
endmodule

bind polyline_simplifier polysim_checker u_polysim_checker (.*);
